// ===== hw/rtl/lsi_pkg.sv =====
// Shared widths and the item type passed between the front and back sections.
package lsi_pkg;

    // Coordinate width and the radius width that follows from it.
    localparam int CW = 32;
    localparam int RADW = CW - 1;

    // Differences of two coordinates carry one more bit.
    localparam int DW = CW + 1;

    // Magnitudes of a, d.e and c, and the two halves used to multiply them.
    localparam int MW = 2 * DW;
    localparam int HW = DW;

    // Magnitude of (d.e) * d_k.
    localparam int NW = MW + DW;

    // Squares and products of the quadratic terms, and their signed difference.
    localparam int SQW = 2 * MW;
    localparam int DFW = SQW + 2;

    // Discriminant output width.
    localparam int DISCW = 64;

    // Divider: dividend 2|n| + a, divisor 2a, quotient bits.
    localparam int RW = NW + 2;
    localparam int DENW = MW + 1;
    localparam int QB = CW + 2;

    // Signed sum of quotient and first point before saturation.
    localparam int SUMW = QB + 2;

    // Queue between the sections.
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    typedef struct packed {
        logic [DISCW-1:0]    disc;
        logic                hit;
        logic                degen;
        logic [2:0][CW-1:0]  p1;
        logic [2:0][NW-1:0]  nmag;
        logic [2:0]          nneg;
        logic [MW-1:0]       a;
    } lsi_item_t;

endpackage

// ===== hw/rtl/lsi_front.sv =====
// Front section: quadratic terms, discriminant and the dividend for the midpoint.
module lsi_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0][lsi_pkg::CW-1:0]          p1,
    input  logic [2:0][lsi_pkg::CW-1:0]          p2,
    input  logic [2:0][lsi_pkg::CW-1:0]          ctr,
    input  logic [lsi_pkg::RADW-1:0]             radius,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output lsi_pkg::lsi_item_t                   out_item
);

    logic [9:1] v_reg;
    logic       en;

    logic [2:0][lsi_pkg::CW-1:0]           p1_reg [1:9];
    logic signed [lsi_pkg::DW-1:0]         d_reg [1:3][3];
    logic signed [lsi_pkg::DW-1:0]         e1_reg [3];
    logic [lsi_pkg::RADW-1:0]              rad1_reg;

    logic signed [lsi_pkg::MW-1:0]         dd2_reg [3];
    logic signed [lsi_pkg::MW-1:0]         de2_reg [3];
    logic signed [lsi_pkg::MW-1:0]         ee2_reg [3];
    logic [2*lsi_pkg::RADW-1:0]            rr2_reg;

    logic [lsi_pkg::MW-1:0]                a_reg [3:9];
    logic signed [lsi_pkg::MW:0]           s3_reg;
    logic signed [lsi_pkg::MW:0]           c3_reg;

    logic [lsi_pkg::MW-1:0]                smag4_reg;
    logic [lsi_pkg::MW-1:0]                cmag4_reg;
    logic [lsi_pkg::DW-1:0]                dmag4_reg [3];
    logic                                  cneg_reg [4:8];
    logic                                  degen_reg [4:9];
    logic [2:0]                            nneg_reg [4:9];

    logic [lsi_pkg::MW-1:0]                ss_ll5_reg, ss_lh5_reg, ss_hh5_reg;
    logic [lsi_pkg::MW-1:0]                ac_ll5_reg, ac_lh5_reg, ac_hl5_reg, ac_hh5_reg;
    logic [lsi_pkg::MW-1:0]                ns_lo5_reg [3];
    logic [lsi_pkg::MW-1:0]                ns_hi5_reg [3];

    logic [lsi_pkg::SQW-1:0]               ss_base6_reg, ac_base6_reg;
    logic [lsi_pkg::MW:0]                  ss_cross6_reg, ac_cross6_reg;
    logic [2:0][lsi_pkg::NW-1:0]           nmag_reg [6:9];

    logic [lsi_pkg::SQW-1:0]               ss7_reg, ac7_reg;
    logic [lsi_pkg::DFW-1:0]               diff8_reg;

    logic [lsi_pkg::DISCW-1:0]             disc9_reg;
    logic                                  hit9_reg;

    logic signed [lsi_pkg::MW:0]           a_sum, s_sum, c_sum;
    logic [lsi_pkg::MW:0]                  s_abs, c_abs;
    logic [lsi_pkg::DW-1:0]                d_abs [3];
    logic [lsi_pkg::DFW-1:lsi_pkg::DISCW-3] diff_top;
    logic                                  diff_fits;

    assign en       = !v_reg[9] || out_ready;
    assign in_ready = en;
    assign out_valid = v_reg[9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[8:1], in_valid};
        end
    end

    always_comb
    begin
        a_sum = dd2_reg[0] + dd2_reg[1] + dd2_reg[2];
        s_sum = de2_reg[0] + de2_reg[1] + de2_reg[2];
        c_sum = ee2_reg[0] + ee2_reg[1] + ee2_reg[2]
                - $signed({{(lsi_pkg::MW+1-2*lsi_pkg::RADW){1'b0}}, rr2_reg});
        s_abs = s3_reg[lsi_pkg::MW] ? -s3_reg : s3_reg;
        c_abs = c3_reg[lsi_pkg::MW] ? -c3_reg : c3_reg;
        for (int k = 0; k < 3; k++)
        begin
            d_abs[k] = d_reg[3][k][lsi_pkg::DW-1] ? -d_reg[3][k] : d_reg[3][k];
        end
        diff_top  = diff8_reg[lsi_pkg::DFW-1:lsi_pkg::DISCW-3];
        diff_fits = (&diff_top) || !(|diff_top);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Differences d = p2 - p1 and e = p1 - ctr.
            p1_reg[1] <= p1;
            for (int k = 0; k < 3; k++)
            begin
                d_reg[1][k] <= {p2[k][lsi_pkg::CW-1], p2[k]} - {p1[k][lsi_pkg::CW-1], p1[k]};
                e1_reg[k]   <= {p1[k][lsi_pkg::CW-1], p1[k]} - {ctr[k][lsi_pkg::CW-1], ctr[k]};
            end
            rad1_reg <= radius;

            // Products of the components.
            for (int k = 0; k < 3; k++)
            begin
                dd2_reg[k] <= d_reg[1][k] * d_reg[1][k];
                de2_reg[k] <= d_reg[1][k] * e1_reg[k];
                ee2_reg[k] <= e1_reg[k] * e1_reg[k];
            end
            rr2_reg <= rad1_reg * rad1_reg;

            // Dot products.
            a_reg[3] <= a_sum[lsi_pkg::MW-1:0];
            s3_reg   <= s_sum;
            c3_reg   <= c_sum;

            // Magnitudes and signs.
            smag4_reg    <= s_abs[lsi_pkg::MW-1:0];
            cmag4_reg    <= c_abs[lsi_pkg::MW-1:0];
            cneg_reg[4]  <= c3_reg[lsi_pkg::MW];
            degen_reg[4] <= (a_reg[3] == '0);
            for (int k = 0; k < 3; k++)
            begin
                dmag4_reg[k]    <= d_abs[k];
                nneg_reg[4][k]  <= (s3_reg[lsi_pkg::MW] == d_reg[3][k][lsi_pkg::DW-1]);
            end

            // Half-width partial products.
            ss_ll5_reg <= smag4_reg[lsi_pkg::HW-1:0] * smag4_reg[lsi_pkg::HW-1:0];
            ss_lh5_reg <= smag4_reg[lsi_pkg::HW-1:0] * smag4_reg[lsi_pkg::MW-1:lsi_pkg::HW];
            ss_hh5_reg <= smag4_reg[lsi_pkg::MW-1:lsi_pkg::HW] * smag4_reg[lsi_pkg::MW-1:lsi_pkg::HW];
            ac_ll5_reg <= a_reg[4][lsi_pkg::HW-1:0] * cmag4_reg[lsi_pkg::HW-1:0];
            ac_lh5_reg <= a_reg[4][lsi_pkg::HW-1:0] * cmag4_reg[lsi_pkg::MW-1:lsi_pkg::HW];
            ac_hl5_reg <= a_reg[4][lsi_pkg::MW-1:lsi_pkg::HW] * cmag4_reg[lsi_pkg::HW-1:0];
            ac_hh5_reg <= a_reg[4][lsi_pkg::MW-1:lsi_pkg::HW] * cmag4_reg[lsi_pkg::MW-1:lsi_pkg::HW];
            for (int k = 0; k < 3; k++)
            begin
                ns_lo5_reg[k] <= smag4_reg[lsi_pkg::HW-1:0] * dmag4_reg[k];
                ns_hi5_reg[k] <= smag4_reg[lsi_pkg::MW-1:lsi_pkg::HW] * dmag4_reg[k];
            end

            // Low and high products do not overlap, so they are concatenated.
            ss_base6_reg  <= {ss_hh5_reg, ss_ll5_reg};
            ss_cross6_reg <= {ss_lh5_reg, 1'b0};
            ac_base6_reg  <= {ac_hh5_reg, ac_ll5_reg};
            ac_cross6_reg <= {1'b0, ac_lh5_reg} + {1'b0, ac_hl5_reg};
            for (int k = 0; k < 3; k++)
            begin
                nmag_reg[6][k] <= {{lsi_pkg::HW{1'b0}}, ns_lo5_reg[k]}
                                  + {ns_hi5_reg[k], {lsi_pkg::HW{1'b0}}};
            end

            ss7_reg <= ss_base6_reg
                       + lsi_pkg::SQW'({ss_cross6_reg, {lsi_pkg::HW{1'b0}}});
            ac7_reg <= ac_base6_reg
                       + lsi_pkg::SQW'({ac_cross6_reg, {lsi_pkg::HW{1'b0}}});

            // Quarter discriminant s*s - a*c.
            if (cneg_reg[7])
            begin
                diff8_reg <= {2'b00, ss7_reg} + {2'b00, ac7_reg};
            end
            else
            begin
                diff8_reg <= {2'b00, ss7_reg} - {2'b00, ac7_reg};
            end

            // Discriminant is four times the difference, saturated.
            if (diff_fits)
            begin
                disc9_reg <= {diff8_reg[lsi_pkg::DISCW-3:0], 2'b00};
            end
            else if (diff8_reg[lsi_pkg::DFW-1])
            begin
                disc9_reg <= {1'b1, {(lsi_pkg::DISCW-1){1'b0}}};
            end
            else
            begin
                disc9_reg <= {1'b0, {(lsi_pkg::DISCW-1){1'b1}}};
            end
            hit9_reg <= !degen_reg[8] && !diff8_reg[lsi_pkg::DFW-1];

            // Carried fields.
            for (int i = 2; i <= 9; i++)
            begin
                p1_reg[i] <= p1_reg[i-1];
            end
            for (int i = 2; i <= 3; i++)
            begin
                d_reg[i] <= d_reg[i-1];
            end
            for (int i = 4; i <= 9; i++)
            begin
                a_reg[i] <= a_reg[i-1];
            end
            for (int i = 5; i <= 9; i++)
            begin
                degen_reg[i] <= degen_reg[i-1];
                nneg_reg[i]  <= nneg_reg[i-1];
            end
            for (int i = 5; i <= 8; i++)
            begin
                cneg_reg[i] <= cneg_reg[i-1];
            end
            for (int i = 7; i <= 9; i++)
            begin
                nmag_reg[i] <= nmag_reg[i-1];
            end
        end
    end

    always_comb
    begin
        out_item.disc  = disc9_reg;
        out_item.hit   = hit9_reg;
        out_item.degen = degen_reg[9];
        out_item.p1    = p1_reg[9];
        out_item.nmag  = nmag_reg[9];
        out_item.nneg  = nneg_reg[9];
        out_item.a     = a_reg[9];
    end

endmodule

// ===== hw/rtl/lsi_queue.sv =====
// Short item queue that decouples the front and back sections.
module lsi_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  lsi_pkg::lsi_item_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lsi_pkg::lsi_item_t  pop_data
);

    lsi_pkg::lsi_item_t        mem_reg [lsi_pkg::QDEPTH];
    logic [lsi_pkg::QAW-1:0]   wr_reg, rd_reg;
    logic [lsi_pkg::QAW:0]     count_reg, count_next;
    logic                      push, pop;

    assign push_ready = (count_reg != (lsi_pkg::QAW+1)'(lsi_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/lsi_back.sv =====
// Back section: pipelined restoring divider and midpoint saturation.
module lsi_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lsi_pkg::lsi_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lsi_pkg::DISCW-1:0]     discriminant,
    output logic                          hit,
    output logic                          degenerate,
    output logic [2:0][lsi_pkg::CW-1:0]   mid
);

    logic [lsi_pkg::QB+1:0]              v_reg;
    logic                                en;

    logic [lsi_pkg::RW-1:0]              rem_reg [0:lsi_pkg::QB][3];
    logic [lsi_pkg::QB-1:0]              q_reg [0:lsi_pkg::QB][3];
    logic [lsi_pkg::DENW-1:0]            den_reg [0:lsi_pkg::QB];
    logic [lsi_pkg::DISCW-1:0]           disc_reg [0:lsi_pkg::QB];
    logic                                hit_reg [0:lsi_pkg::QB];
    logic                                degen_reg [0:lsi_pkg::QB];
    logic [2:0][lsi_pkg::CW-1:0]         p1_reg [0:lsi_pkg::QB];
    logic [2:0]                          nneg_reg [0:lsi_pkg::QB];

    logic [lsi_pkg::DISCW-1:0]           disc_out_reg;
    logic                                hit_out_reg, degen_out_reg;
    logic [2:0][lsi_pkg::CW-1:0]         mid_out_reg;

    logic signed [lsi_pkg::SUMW-1:0]     qs [3];
    logic signed [lsi_pkg::SUMW-1:0]     msum [3];
    logic [lsi_pkg::SUMW-1:lsi_pkg::CW-1] mtop [3];
    logic [2:0][lsi_pkg::CW-1:0]         msat;

    assign en           = !v_reg[lsi_pkg::QB+1] || out_ready;
    assign in_ready     = en;
    assign out_valid    = v_reg[lsi_pkg::QB+1];
    assign discriminant = disc_out_reg;
    assign hit          = hit_out_reg;
    assign degenerate   = degen_out_reg;
    assign mid          = mid_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[lsi_pkg::QB:0], in_valid};
        end
    end

    // Entry stage: dividend 2|n| + a and divisor 2a give the rounded quotient.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[0][k] <= {1'b0, in_item.nmag[k], 1'b0}
                                 + {{(lsi_pkg::RW-lsi_pkg::MW){1'b0}}, in_item.a};
                q_reg[0][k]   <= '0;
            end
            den_reg[0]   <= {in_item.a, 1'b0};
            disc_reg[0]  <= in_item.disc;
            hit_reg[0]   <= in_item.hit;
            degen_reg[0] <= in_item.degen;
            p1_reg[0]    <= in_item.p1;
            nneg_reg[0]  <= in_item.nneg;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 1; j <= lsi_pkg::QB; j++)
    begin : g_div
        localparam int B = lsi_pkg::QB - j;
        logic [lsi_pkg::RW:0] trial [3];

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                trial[k] = {1'b0, rem_reg[j-1][k]}
                           - {1'b0, lsi_pkg::RW'(den_reg[j-1]) << B};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (!trial[k][lsi_pkg::RW])
                    begin
                        rem_reg[j][k]  <= trial[k][lsi_pkg::RW-1:0];
                        q_reg[j][k]    <= q_reg[j-1][k] | (lsi_pkg::QB'(1) << B);
                    end
                    else
                    begin
                        rem_reg[j][k]  <= rem_reg[j-1][k];
                        q_reg[j][k]    <= q_reg[j-1][k];
                    end
                end
                den_reg[j]   <= den_reg[j-1];
                disc_reg[j]  <= disc_reg[j-1];
                hit_reg[j]   <= hit_reg[j-1];
                degen_reg[j] <= degen_reg[j-1];
                p1_reg[j]    <= p1_reg[j-1];
                nneg_reg[j]  <= nneg_reg[j-1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (nneg_reg[lsi_pkg::QB][k])
            begin
                qs[k] = -$signed({2'b00, q_reg[lsi_pkg::QB][k]});
            end
            else
            begin
                qs[k] = $signed({2'b00, q_reg[lsi_pkg::QB][k]});
            end
            msum[k] = qs[k] + $signed({{(lsi_pkg::SUMW-lsi_pkg::CW){p1_reg[lsi_pkg::QB][k][lsi_pkg::CW-1]}},
                                       p1_reg[lsi_pkg::QB][k]});
            mtop[k] = msum[k][lsi_pkg::SUMW-1:lsi_pkg::CW-1];
            if ((&mtop[k]) || !(|mtop[k]))
            begin
                msat[k] = msum[k][lsi_pkg::CW-1:0];
            end
            else if (msum[k][lsi_pkg::SUMW-1])
            begin
                msat[k] = {1'b1, {(lsi_pkg::CW-1){1'b0}}};
            end
            else
            begin
                msat[k] = {1'b0, {(lsi_pkg::CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc_out_reg  <= disc_reg[lsi_pkg::QB];
            hit_out_reg   <= hit_reg[lsi_pkg::QB];
            degen_out_reg <= degen_reg[lsi_pkg::QB];
            mid_out_reg   <= hit_reg[lsi_pkg::QB] ? msat : '0;
        end
    end

endmodule

// ===== hw/rtl/line_sphere_intersect_core.sv =====
// Throughput: one item per cycle while the output is not held; every stage is pipelined,
// including the 34-stage divider, which resolves one quotient bit per stage for each axis.
// Reset (rst_n, asynchronous, active low) empties every stage and the item queue.
// Data registers are not reset; they are only ever read behind a valid bit.
module line_sphere_intersect_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [lsi_pkg::CW-1:0]     p1_x,
    input  logic signed [lsi_pkg::CW-1:0]     p1_y,
    input  logic signed [lsi_pkg::CW-1:0]     p1_z,
    input  logic signed [lsi_pkg::CW-1:0]     p2_x,
    input  logic signed [lsi_pkg::CW-1:0]     p2_y,
    input  logic signed [lsi_pkg::CW-1:0]     p2_z,
    input  logic signed [lsi_pkg::CW-1:0]     ctr_x,
    input  logic signed [lsi_pkg::CW-1:0]     ctr_y,
    input  logic signed [lsi_pkg::CW-1:0]     ctr_z,
    input  logic [lsi_pkg::RADW-1:0]          radius,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [lsi_pkg::DISCW-1:0]  discriminant,
    output logic                              hit,
    output logic                              degenerate,
    output logic signed [lsi_pkg::CW-1:0]     mid_x,
    output logic signed [lsi_pkg::CW-1:0]     mid_y,
    output logic signed [lsi_pkg::CW-1:0]     mid_z
);

    // The front section forms a = d.d, s = d.e and c = e.e - r*r, the discriminant
    // 4*(s*s - a*c) and the magnitude of -(s*d_k) for each axis. It runs in nine
    // stages and stalls only when the queue behind it is full.
    logic [2:0][lsi_pkg::CW-1:0] p1_vec, p2_vec, ctr_vec;
    logic [2:0][lsi_pkg::CW-1:0] mid_vec;
    logic [lsi_pkg::DISCW-1:0]   disc_w;

    // Items travel between the sections as one packed struct.
    lsi_pkg::lsi_item_t front_item, back_item;
    logic               front_valid, front_ready;
    logic               back_valid, back_ready;

    assign p1_vec  = {p1_z, p1_y, p1_x};
    assign p2_vec  = {p2_z, p2_y, p2_x};
    assign ctr_vec = {ctr_z, ctr_y, ctr_x};

    lsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .p1        (p1_vec),
        .p2        (p2_vec),
        .ctr       (ctr_vec),
        .radius    (radius),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    // The queue lets the front keep accepting items while the output is held.
    lsi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_item)
    );

    // The back section divides by 2a with rounding to nearest, ties away from
    // zero, adds the first point and saturates. Its last stage is the output register.
    // The queue's fullness comes from a register, so out_ready never reaches in_ready in the same cycle.
    lsi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (back_valid),
        .in_ready     (back_ready),
        .in_item      (back_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .discriminant (disc_w),
        .hit          (hit),
        .degenerate   (degenerate),
        .mid          (mid_vec)
    );

    assign discriminant = disc_w;
    assign mid_x = mid_vec[0];
    assign mid_y = mid_vec[1];
    assign mid_z = mid_vec[2];

endmodule

// ===== hw/rtl/lsi_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module lsi_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [lsi_pkg::DISCW-1:0]     discriminant,
    input logic                          hit,
    input logic                          degenerate,
    input logic [lsi_pkg::CW-1:0]        mid_x,
    input logic [lsi_pkg::CW-1:0]        mid_y,
    input logic [lsi_pkg::CW-1:0]        mid_z
);

    // A held result keeps its discriminant and mid_x.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(discriminant) && $stable(mid_x))
        else $error("result changed while stalled");

    // A hit never comes from a degenerate line or a negative discriminant.
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !degenerate && !discriminant[lsi_pkg::DISCW-1])
        else $error("hit with degenerate line or negative discriminant");

    // Without a hit the midpoint is zero.
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> mid_x == '0 && mid_y == '0 && mid_z == '0)
        else $error("nonzero midpoint without hit");

    // A degenerate line has a zero discriminant.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> discriminant == '0)
        else $error("degenerate line with nonzero discriminant");

endmodule

bind line_sphere_intersect_core lsi_checker u_lsi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .discriminant (discriminant),
    .hit          (hit),
    .degenerate   (degenerate),
    .mid_x        (mid_x),
    .mid_y        (mid_y),
    .mid_z        (mid_z)
);

// ===== sim/line_sphere_intersect_core_test.sv =====
// Self-checking testbench for the line and sphere intersection core.
`timescale 1ns / 1ps

module line_sphere_intersect_core_test;

    localparam int CW = lsi_pkg::CW;
    localparam int RADW = lsi_pkg::RADW;
    localparam int DISCW = lsi_pkg::DISCW;

    // One line and sphere query as it is offered on the input channel.
    typedef struct packed {
        logic [2:0][CW-1:0] p1;
        logic [2:0][CW-1:0] p2;
        logic [2:0][CW-1:0] ctr;
        logic [RADW-1:0]    rad;
    } query_t;

    // The answer that the core must produce for one query.
    typedef struct packed {
        logic signed [DISCW-1:0] disc;
        logic                    hit;
        logic                    degen;
        logic [2:0][CW-1:0]      mid;
    } answer_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD = 400;
    localparam int RANDOM_QUERIES = 1200;

    // Wide signed bounds used to saturate the exact results.
    localparam logic signed [255:0] DISC_MAX = 256'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [255:0] DISC_MIN = -DISC_MAX - 1;
    localparam logic signed [255:0] COORD_MAX = (256'sd1 <<< (CW - 1)) - 1;
    localparam logic signed [255:0] COORD_MIN = -COORD_MAX - 1;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE = 32'h0001_0000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [CW-1:0] p1_x, p1_y, p1_z;
    logic signed [CW-1:0] p2_x, p2_y, p2_z;
    logic signed [CW-1:0] ctr_x, ctr_y, ctr_z;
    logic [RADW-1:0] radius;
    logic out_valid;
    logic out_ready;
    logic signed [DISCW-1:0] discriminant;
    logic hit;
    logic degenerate;
    logic signed [CW-1:0] mid_x, mid_y, mid_z;

    // Queries still to be offered, and answers still owed by the core.
    query_t  pending_queries[$];
    answer_t owed_answers[$];

    int  error_count = 0;
    int  accepted_count = 0;
    int  idle_cycles = 0;
    bit  query_taken = 0;
    int  burst_left = 4;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    int  ready_mode = 0;
    int  mode_cycles = 0;

    line_sphere_intersect_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .p1_x         (p1_x),
        .p1_y         (p1_y),
        .p1_z         (p1_z),
        .p2_x         (p2_x),
        .p2_y         (p2_y),
        .p2_z         (p2_z),
        .ctr_x        (ctr_x),
        .ctr_y        (ctr_y),
        .ctr_z        (ctr_z),
        .radius       (radius),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .discriminant (discriminant),
        .hit          (hit),
        .degenerate   (degenerate),
        .mid_x        (mid_x),
        .mid_y        (mid_y),
        .mid_z        (mid_z)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Exact intersection math in 256-bit integers. With d = P2-P1 and e = P1-C the
    // quadratic terms are a = d.d, b = 2 d.e and c = e.e - R*R. The midpoint of the two
    // roots is P1 - (d.e/a) d, which needs no square root; each axis offset is rounded
    // to nearest with ties away from zero, then added to P1 and saturated.
    function automatic answer_t predict_answer(query_t q);
        logic signed [255:0] p1v[3];
        logic signed [255:0] dv[3];
        logic signed [255:0] ev[3];
        logic signed [255:0] a, s, c, b, disc, n, quot, total;
        logic [255:0] mag;
        answer_t r;
        a = 0;
        s = 0;
        c = 0;
        for (int k = 0; k < 3; k++)
        begin
            p1v[k] = $signed(q.p1[k]);
            dv[k] = $signed(q.p2[k]) - p1v[k];
            ev[k] = p1v[k] - $signed(q.ctr[k]);
            a = a + dv[k] * dv[k];
            s = s + dv[k] * ev[k];
            c = c + ev[k] * ev[k];
        end
        c = c - $signed({225'd0, q.rad}) * $signed({225'd0, q.rad});
        b = s + s;
        disc = b * b - 4 * a * c;
        if (disc > DISC_MAX)
            r.disc = DISC_MAX[63:0];
        else if (disc < DISC_MIN)
            r.disc = DISC_MIN[63:0];
        else
            r.disc = disc[63:0];
        r.degen = (a == 0);
        r.hit = !r.degen && !disc[255];
        for (int k = 0; k < 3; k++)
        begin
            r.mid[k] = '0;
            if (r.hit)
            begin
                n = -(s * dv[k]);
                mag = n[255] ? -n : n;
                quot = (2 * mag + a) / (2 * a);
                if (n[255])
                    quot = -quot;
                total = quot + p1v[k];
                if (total > COORD_MAX)
                    total = COORD_MAX;
                else if (total < COORD_MIN)
                    total = COORD_MIN;
                r.mid[k] = total[CW-1:0];
            end
        end
        return r;
    endfunction

    function automatic query_t make_query(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                          logic [CW-1:0] az, logic [CW-1:0] bx,
                                          logic [CW-1:0] by, logic [CW-1:0] bz,
                                          logic [CW-1:0] cx, logic [CW-1:0] cy,
                                          logic [CW-1:0] cz, logic [RADW-1:0] r);
        query_t q;
        q.p1 = {az, ay, ax};
        q.p2 = {bz, by, bx};
        q.ctr = {cz, cy, cx};
        q.rad = r;
        return q;
    endfunction

    // A coordinate within +/- span of base, wrapping like the raw 32-bit field does.
    function automatic logic [CW-1:0] near(logic [CW-1:0] base, int unsigned span);
        return base + $urandom_range(0, 2 * span) - span;
    endfunction

    // Random queries: mostly geometry that can hit, with full-range noise and
    // degenerate lines mixed in.
    function automatic query_t random_query();
        query_t q;
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 9);
        span = 1 << $urandom_range(4, 22);
        for (int k = 0; k < 3; k++)
        begin
            q.p1[k] = (pick >= 8) ? ($urandom >> 1) ^ {CW{$urandom_range(0, 1) == 1}}
                                  : $urandom;
            q.p2[k] = near(q.p1[k], span);
            q.ctr[k] = near(q.p1[k], span * 4);
        end
        q.rad = RADW'($urandom_range(0, span * 6));
        if (pick <= 1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                q.p2[k] = $urandom;
                q.ctr[k] = $urandom;
            end
            q.rad = RADW'($urandom);
        end
        else if (pick == 7)
            q.p2 = q.p1;
        else if (pick >= 8)
            q.rad = RADW'($urandom);
        return q;
    endfunction

    // Reset and stimulus. The directed queries come first, then the random mix.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        {p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, ctr_x, ctr_y, ctr_z} = '0;
        radius = '0;

        // Degenerate lines: at the origin and at the positive corner.
        pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_queries.push_back(make_query(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                                             CMIN, CMIN, CMIN, {RADW{1'b1}}));
        // Corner to corner: the discriminant saturates high.
        pending_queries.push_back(make_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                                             0, 0, 0, {RADW{1'b1}}));
        // Far miss with zero radius: the discriminant saturates low.
        pending_queries.push_back(make_query(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN,
                                             CMAX, CMAX, CMIN, 0));
        // Plain secant, tangent and miss along the x axis.
        pending_queries.push_back(make_query(0, 0, 0, ONE, 0, 0, 5 * ONE, ONE, 0, 2 * ONE));
        pending_queries.push_back(make_query(0, 0, 0, ONE, 0, 0, 5 * ONE, ONE, 0, ONE));
        pending_queries.push_back(make_query(0, 0, 0, ONE, 0, 0, 5 * ONE, ONE, 0, ONE / 2));
        // Rounding ties of the midpoint, positive and negative.
        pending_queries.push_back(make_query(0, 0, 0, 2, 2, 0, 1, 0, 0, ONE));
        pending_queries.push_back(make_query(0, 0, 0, 2, 2, 0, -1, 0, 0, ONE));
        pending_queries.push_back(make_query(0, 0, 0, 2, 2, 0, 3, 0, 0, ONE));
        // Midpoint beyond the coordinate range on the y axis.
        pending_queries.push_back(make_query(CMAX, 0, 0, CMAX - 1, 1, 0, CMIN, CMAX, 0,
                                             {RADW{1'b1}}));
        pending_queries.push_back(make_query(CMIN, 0, 0, CMIN + 1, -1, 0, CMAX, CMIN, 0,
                                             {RADW{1'b1}}));
        // Short line segments at the corners of the coordinate range, with a large radius.
        pending_queries.push_back(make_query(CMIN, CMIN, CMIN, CMIN + 1, CMIN, CMIN,
                                             0, 0, 0, {RADW{1'b1}}));
        pending_queries.push_back(make_query(CMAX, CMAX, 0, CMAX, CMAX - 1, 0,
                                             CMAX, CMAX, CMAX, {RADW{1'b1}}));
        for (int i = 0; i < RANDOM_QUERIES; i++)
            pending_queries.push_back(random_query());

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Drain: everything offered, everything answered, then quiet cycles to catch
        // any stray result.
        while (pending_queries.size() != 0 || owed_answers.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0 && owed_answers.size() == 0)
            $display("line_sphere_intersect_core test passed");
        else
            $display("line_sphere_intersect_core test failed");
        $finish;
    end

    // Sender: offers queries in bursts with random gaps. A query stays on the bus,
    // unchanged, until the core takes it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !query_taken)
            begin
                // Still waiting for the core to take the current item.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_queries.size() != 0)
            begin
                {p1_z, p1_y, p1_x} <= pending_queries[0].p1;
                {p2_z, p2_y, p2_x} <= pending_queries[0].p2;
                {ctr_z, ctr_y, ctr_x} <= pending_queries[0].ctr;
                radius <= pending_queries[0].rad;
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
            query_taken = 0;
        end
    end

    // Receiver: cycles through stall patterns, and once holds off long enough
    // for the pipeline and its queue to fill and push back on the input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && accepted_count >= 300)
            begin
                hold_done = 1;
                hold_left = LONG_HOLD;
            end
            mode_cycles++;
            if (mode_cycles >= 64)
            begin
                mode_cycles = 0;
                ready_mode = $urandom_range(0, 3);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (ready_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= mode_cycles[0];
                endcase
            end
        end
    end

    // Input side: every accepted item is answered ahead of time by the model.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            owed_answers.push_back(predict_answer(pending_queries[0]));
            void'(pending_queries.pop_front());
            query_taken = 1;
            accepted_count++;
        end
    end

    // Output side: every accepted result is checked against the oldest owed answer.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (owed_answers.size() == 0)
            begin
                $error("result arrived with no item outstanding");
                error_count++;
            end
            else
            begin
                want = owed_answers.pop_front();
                if (discriminant !== want.disc)
                begin
                    $error("discriminant mismatch: expected %0d, actual %0d",
                           want.disc, discriminant);
                    error_count++;
                end
                if (hit !== want.hit)
                begin
                    $error("hit mismatch: expected %0d, actual %0d", want.hit, hit);
                    error_count++;
                end
                if (degenerate !== want.degen)
                begin
                    $error("degenerate mismatch: expected %0d, actual %0d",
                           want.degen, degenerate);
                    error_count++;
                end
                if (mid_x !== $signed(want.mid[0]))
                begin
                    $error("mid_x mismatch: expected %0d, actual %0d",
                           $signed(want.mid[0]), mid_x);
                    error_count++;
                end
                if (mid_y !== $signed(want.mid[1]))
                begin
                    $error("mid_y mismatch: expected %0d, actual %0d",
                           $signed(want.mid[1]), mid_y);
                    error_count++;
                end
                if (mid_z !== $signed(want.mid[2]))
                begin
                    $error("mid_z mismatch: expected %0d, actual %0d",
                           $signed(want.mid[2]), mid_z);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("line_sphere_intersect_core test failed");
            $finish;
        end
    end

endmodule
